// File: src/hnm_pkg.sv
// Shared types and constants for the heightmap normal-map stencil.
// Used by hnm_normal and heightmap_normal_map_stencil_top; no dependencies.
package hnm_pkg;

  // Stream and configuration port widths
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 56;
  localparam int CFG_INDEX_W = 3;

  // Configuration register indexes
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_WIDTH  = 3'd0,
    REG_HEIGHT = 3'd1,
    REG_GAIN   = 3'd2,
    REG_STEP_X = 3'd3,
    REG_STEP_Z = 3'd4
  } cfg_reg_t;

  // One normal to compute: four stencil taps, span flags, scale factors
  typedef struct packed {
    logic [31:0] left;
    logic [31:0] right;
    logic [31:0] up;
    logic [31:0] down;
    logic        cf2;     // column span is two (interior)
    logic        rf2;     // row span is two (interior)
    logic [31:0] gain;
    logic [31:0] sx;
    logic [31:0] sz;
  } nreq_t;

  // Status and result of the normal unit
  typedef struct packed {
    logic       valid;
    logic       busy;
    logic [7:0] byte_up;
    logic [7:0] byte_depth;
    logic [7:0] byte_across;
  } nres_t;

endpackage

// File: src/heightmap_normal_map_stencil_top.sv
// Heightmap to normal map: two line-buffer memories, stencil fetch, normal unit.
// Each sample is fetched and written back, then the normals it completes are computed
// one after another (shared multiplier, 32-step square root, 3 x 9-step divide).
// Throughput: one sample at a time; the next sample is taken only once every normal
// that it completes (up to three on the last row) has been computed and handed on.
// Reset: counters to zero, registers to defaults; line buffers are not cleared.
module heightmap_normal_map_stencil_top #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [hnm_pkg::IN_TDATA_W-1:0]  s_tdata,   // [31:0] height_sample
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // [9:0] out_x, [25:10] out_y, [33:26] byte_up, [41:34] byte_depth,
  // [49:42] byte_across, [55:50] zero
  output logic [hnm_pkg::OUT_TDATA_W-1:0] m_tdata,
  output logic                            m_tlast,   // last
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [hnm_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [31:0]                     cfg_data
);
  import hnm_pkg::*;

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int CW = AW + 1;

  typedef enum logic [3:0] {
    T_IDLE  = 4'b0001,
    T_READ  = 4'b0010,
    T_WRITE = 4'b0100,
    T_CALC  = 4'b1000
  } tstate_t;

  tstate_t        state;
  logic [10:0]    cfg_w;
  logic [15:0]    cfg_h;
  logic [31:0]    cfg_g, cfg_sx, cfg_sz;
  logic [CW-1:0]  w, wm1;
  logic [15:0]    h, hm1;
  logic [AW-1:0]  col, x_now, x_q;
  logic [15:0]    row, y_now, y_q;
  logic [31:0]    s_q;
  logic           in_acc;
  logic [2:0]     rk;
  logic [AW-1:0]  cur_ra, abv_ra;
  logic [31:0]    cur_rd, abv_rd;
  logic [31:0]    mid, above, right_raw, left_raw, l2, dn;
  logic [31:0]    mem_cur [MAX_WIDTH];
  logic [31:0]    mem_abv [MAX_WIDTH];
  logic           mem_we;
  logic           x_first, x_lastc, y_top, y_lastr;
  logic [2:0]     pend;
  nreq_t          nreq;
  nres_t          nres;
  logic           n_start, out_load;
  logic [AW-1:0]  sel_x, tag_x;
  logic [15:0]    sel_y, tag_y;
  logic           sel_last, tag_last;

  // effective image size
  always_comb begin
    if (cfg_w < 11'd2) begin
      w = CW'(2);
    end else if ({21'b0, cfg_w} > 32'(MAX_WIDTH)) begin
      w = CW'(MAX_WIDTH);
    end else begin
      w = CW'(cfg_w);
    end
    h     = (cfg_h < 16'd2) ? 16'd2 : cfg_h;
    wm1   = w - CW'(1);
    hm1   = h - 16'd1;
    x_now = ({1'b0, col} > wm1) ? wm1[AW-1:0] : col;
    y_now = (row > hm1) ? hm1 : row;
  end

  assign s_tready = (state == T_IDLE);
  assign in_acc   = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_w  <= 11'd2;
      cfg_h  <= 16'd2;
      cfg_g  <= 32'd65536;
      cfg_sx <= 32'd65536;
      cfg_sz <= 32'd65536;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_WIDTH:  cfg_w  <= cfg_data[10:0];
        REG_HEIGHT: cfg_h  <= cfg_data[15:0];
        REG_GAIN:   cfg_g  <= cfg_data;
        REG_STEP_X: cfg_sx <= cfg_data;
        REG_STEP_Z: cfg_sz <= cfg_data;
        default: ;
      endcase
    end
  end

  // position flags of the current sample
  assign x_first = (x_q == '0);
  assign x_lastc = ({1'b0, x_q} == wm1);
  assign y_top   = (y_q == 16'd1);
  assign y_lastr = (y_q == hm1);

  // stencil fetch addresses, one read per memory per cycle
  always_comb begin
    cur_ra = x_q;
    abv_ra = x_q;
    unique case (rk)
      3'd1:    begin cur_ra = x_q + AW'(1); abv_ra = x_q - AW'(1); end
      3'd2:    cur_ra = (x_q == AW'(1)) ? '0 : x_q - AW'(2);
      3'd3:    cur_ra = x_q - AW'(1);
      default: ;
    endcase
  end

  assign mem_we = (state == T_WRITE);

  // line buffers: current row and row above
  always_ff @(posedge clk) begin
    cur_rd <= mem_cur[cur_ra];
    abv_rd <= mem_abv[abv_ra];
    if (mem_we) begin
      mem_cur[x_q] <= s_q;
      mem_abv[x_q] <= mid;
    end
  end

  // normal request, pending normals in order
  always_comb begin
    nreq.gain = cfg_g;
    nreq.sx   = cfg_sx;
    nreq.sz   = cfg_sz;
    if (pend[0]) begin
      nreq.left  = x_first ? mid : left_raw;
      nreq.right = x_lastc ? mid : right_raw;
      nreq.up    = y_top ? mid : above;
      nreq.down  = s_q;
      nreq.cf2   = !(x_first || x_lastc);
      nreq.rf2   = !y_top;
      sel_x      = x_q;
      sel_y      = y_q - 16'd1;
      sel_last   = 1'b0;
    end else if (pend[1]) begin
      nreq.left  = l2;
      nreq.right = s_q;
      nreq.up    = left_raw;
      nreq.down  = dn;
      nreq.cf2   = (x_q != AW'(1));
      nreq.rf2   = 1'b0;
      sel_x      = x_q - AW'(1);
      sel_y      = y_q;
      sel_last   = 1'b0;
    end else begin
      nreq.left  = dn;
      nreq.right = s_q;
      nreq.up    = mid;
      nreq.down  = s_q;
      nreq.cf2   = 1'b0;
      nreq.rf2   = 1'b0;
      sel_x      = x_q;
      sel_y      = y_q;
      sel_last   = 1'b1;
    end
  end

  assign n_start  = (state == T_CALC) && !nres.busy && (pend != '0);
  assign out_load = nres.valid && (!m_tvalid || m_tready);

  hnm_normal u_normal (
    .clk   (clk),
    .rst   (rst),
    .start (n_start),
    .req   (nreq),
    .take  (out_load),
    .res   (nres)
  );

  // sample sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= T_IDLE;
      col   <= '0;
      row   <= '0;
      pend  <= '0;
      rk    <= '0;
    end else begin
      unique case (state)
        T_IDLE: begin
          if (in_acc) begin
            s_q <= s_tdata;
            x_q <= x_now;
            y_q <= y_now;
            rk  <= '0;
            if ({1'b0, x_now} >= wm1) begin
              col <= '0;
              row <= (y_now >= hm1) ? 16'd0 : y_now + 16'd1;
            end else begin
              col <= x_now + AW'(1);
              row <= y_now;
            end
            state <= T_READ;
          end
        end
        T_READ: begin
          rk <= rk + 3'd1;
          unique case (rk)
            3'd1: begin mid <= cur_rd; above <= abv_rd; end
            3'd2: begin right_raw <= cur_rd; left_raw <= abv_rd; end
            3'd3: l2 <= cur_rd;
            3'd4: begin dn <= cur_rd; state <= T_WRITE; end
            default: ;
          endcase
        end
        T_WRITE: begin
          pend  <= {y_lastr && x_lastc, y_lastr && !x_first, y_q != 16'd0};
          state <= T_CALC;
        end
        T_CALC: begin
          if (n_start) begin
            tag_x    <= sel_x;
            tag_y    <= sel_y;
            tag_last <= sel_last;
            if (pend[0]) begin
              pend[0] <= 1'b0;
            end else if (pend[1]) begin
              pend[1] <= 1'b0;
            end else begin
              pend[2] <= 1'b0;
            end
          end else if (pend == '0 && !nres.busy) begin
            state <= T_IDLE;
          end
        end
        default: state <= T_IDLE;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
    if (out_load) begin
      m_tdata <= {6'b0, nres.byte_across, nres.byte_depth, nres.byte_up, tag_y, 10'(tag_x)};
      m_tlast <= tag_last;
    end
  end

endmodule

// File: src/hnm_normal.sv
// Iterative normal unit: cross product, normalize, square root, byte packing.
// Depends on hnm_pkg (nreq_t, nres_t). One shared 32x32 multiplier.
module hnm_normal (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  hnm_pkg::nreq_t req,
  input  logic          take,
  output hnm_pkg::nres_t res
);
  import hnm_pkg::*;

  localparam int MW = 98;   // product magnitude width
  localparam int NW = 43;   // signed numerator width
  localparam int RW = 42;   // divider remainder width
  localparam logic [7:0] BYTE_MID = 8'd128;

  typedef enum logic [6:0] {
    N_IDLE = 7'b0000001,
    N_MUL  = 7'b0000010,
    N_NORM = 7'b0000100,
    N_SQ   = 7'b0001000,
    N_SQRT = 7'b0010000,
    N_DIV  = 7'b0100000,
    N_DONE = 7'b1000000
  } nstate_t;

  nstate_t        state;
  nreq_t          rq;
  logic [3:0]     step;
  logic [63:0]    prod, t0, t2;
  logic [MW-1:0]  m0, m1, m2, mo;
  logic [32:0]    dx, dz;
  logic [31:0]    adx, adz;
  logic           neg0, neg2;
  logic [31:0]    mul_a, mul_b;
  logic [63:0]    rt_s, rt_res, rt_one, rt_sum;
  logic [1:0]     k;
  logic [3:0]     bi;
  logic           dsetup;
  logic [RW-1:0]  rem, dsh;
  logic [8:0]     q, q_next;
  logic           hit;
  logic [30:0]    mag;
  logic           magneg;
  logic [38:0]    v255;
  logic [NW-1:0]  num;
  logic [7:0]     qbyte, div_byte;
  logic           div_store;
  logic [7:0]     b_up, b_depth, b_across;

  // differences and signs
  assign dx   = {rq.right[31], rq.right} - {rq.left[31], rq.left};
  assign dz   = {rq.down[31], rq.down} - {rq.up[31], rq.up};
  assign adx  = dx[32] ? 32'(-dx) : dx[31:0];
  assign adz  = dz[32] ? 32'(-dz) : dz[31:0];
  assign neg0 = !dx[32] && (dx != '0);
  assign neg2 = dz[32];
  assign mo   = m0 | m1 | m2;

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state == N_SQ) begin
      unique case (step)
        4'd0:    begin mul_a = {1'b0, m0[30:0]}; mul_b = {1'b0, m0[30:0]}; end
        4'd1:    begin mul_a = {1'b0, m1[30:0]}; mul_b = {1'b0, m1[30:0]}; end
        default: begin mul_a = {1'b0, m2[30:0]}; mul_b = {1'b0, m2[30:0]}; end
      endcase
    end else begin
      unique case (step)
        4'd0:    begin mul_a = rq.gain;     mul_b = adx;   end
        4'd1:    begin mul_a = rq.gain;     mul_b = adz;   end
        4'd2:    begin mul_a = rq.sx;       mul_b = rq.sz; end
        4'd3:    begin mul_a = t0[31:0];    mul_b = rq.sz; end
        4'd4:    begin mul_a = t0[63:32];   mul_b = rq.sz; end
        4'd5:    begin mul_a = t2[31:0];    mul_b = rq.sx; end
        4'd6:    begin mul_a = t2[63:32];   mul_b = rq.sx; end
        default: begin mul_a = '0;          mul_b = '0;    end
      endcase
    end
  end

  // square root step
  assign rt_sum = rt_res + rt_one;

  // byte packing: numerator 256*len +/- 255*|v|, restoring divide by 2*len
  always_comb begin
    unique case (k)
      2'd0:    begin mag = m1[30:0]; magneg = 1'b0; end
      2'd1:    begin mag = m2[30:0]; magneg = neg2; end
      default: begin mag = m0[30:0]; magneg = neg0; end
    endcase
  end
  assign v255   = {mag, 8'b0} - {8'b0, mag};
  assign num    = magneg ? ({3'b0, rt_res[31:0], 8'b0} - {4'b0, v255})
                         : ({3'b0, rt_res[31:0], 8'b0} + {4'b0, v255});
  assign dsh    = RW'({rt_res[31:0], 1'b0}) << bi;
  assign hit    = rem >= dsh;
  assign q_next = q | (9'(hit) << bi);
  assign qbyte  = q_next[8] ? 8'hFF : q_next[7:0];
  assign div_store = (state == N_DIV) && ((dsetup && num[NW-1]) || (!dsetup && bi == 4'd0));
  assign div_byte  = dsetup ? 8'd0 : qbyte;

  // sequencer and datapath
  always_ff @(posedge clk) begin
    prod <= 64'(mul_a) * 64'(mul_b);
    if (rst) begin
      state <= N_IDLE;
    end else begin
      unique case (state)
        N_IDLE: begin
          if (start) begin
            rq    <= req;
            step  <= '0;
            state <= N_MUL;
          end
        end
        N_MUL: begin
          step <= step + 4'd1;
          unique case (step)
            4'd1: t0 <= prod;
            4'd2: t2 <= prod;
            4'd3: m1 <= MW'(prod);
            4'd4: m0 <= MW'(prod);
            4'd5: m0 <= m0 + (MW'(prod) << 32);
            4'd6: m2 <= MW'(prod);
            4'd7: m2 <= m2 + (MW'(prod) << 32);
            4'd8: begin
              m0    <= rq.rf2 ? (m0 << 1) : m0;
              m1    <= m1 << ({1'b0, rq.cf2} + {1'b0, rq.rf2});
              m2    <= rq.cf2 ? (m2 << 1) : m2;
              state <= N_NORM;
            end
            default: ;
          endcase
        end
        N_NORM: begin
          // bring the largest magnitude's top bit to bit 30
          if (mo == '0) begin
            b_up     <= BYTE_MID;
            b_depth  <= BYTE_MID;
            b_across <= BYTE_MID;
            state    <= N_DONE;
          end else if (|mo[MW-1:39]) begin
            m0 <= m0 >> 8; m1 <= m1 >> 8; m2 <= m2 >> 8;
          end else if (|mo[MW-1:31]) begin
            m0 <= m0 >> 1; m1 <= m1 >> 1; m2 <= m2 >> 1;
          end else if (~|mo[MW-1:23]) begin
            m0 <= m0 << 8; m1 <= m1 << 8; m2 <= m2 << 8;
          end else if (!mo[30]) begin
            m0 <= m0 << 1; m1 <= m1 << 1; m2 <= m2 << 1;
          end else begin
            step  <= '0;
            state <= N_SQ;
          end
        end
        N_SQ: begin
          step <= step + 4'd1;
          unique case (step)
            4'd1: rt_s <= prod;
            4'd2: rt_s <= rt_s + prod;
            4'd3: begin
              rt_s   <= rt_s + prod;
              rt_res <= '0;
              rt_one <= 64'h4000_0000_0000_0000;
              state  <= N_SQRT;
            end
            default: ;
          endcase
        end
        N_SQRT: begin
          if (rt_s >= rt_sum) begin
            rt_s   <= rt_s - rt_sum;
            rt_res <= (rt_res >> 1) + rt_one;
          end else begin
            rt_res <= rt_res >> 1;
          end
          rt_one <= rt_one >> 2;
          if (rt_one == 64'd1) begin
            k      <= '0;
            dsetup <= 1'b1;
            state  <= N_DIV;
          end
        end
        N_DIV: begin
          if (div_store) begin
            unique case (k)
              2'd0:    b_up     <= div_byte;
              2'd1:    b_depth  <= div_byte;
              default: b_across <= div_byte;
            endcase
            if (k == 2'd2) begin
              state <= N_DONE;
            end else begin
              k      <= k + 2'd1;
              dsetup <= 1'b1;
            end
          end else if (dsetup) begin
            rem    <= num[RW-1:0];
            q      <= '0;
            bi     <= 4'd8;
            dsetup <= 1'b0;
          end else begin
            if (hit) rem <= rem - dsh;
            q  <= q_next;
            bi <= bi - 4'd1;
          end
        end
        N_DONE: begin
          if (take) state <= N_IDLE;
        end
        default: state <= N_IDLE;
      endcase
    end
  end

  assign res.valid       = (state == N_DONE);
  assign res.busy        = (state != N_IDLE);
  assign res.byte_up     = b_up;
  assign res.byte_depth  = b_depth;
  assign res.byte_across = b_across;

endmodule

// File: bench/heightmap_normal_map_stencil_top_tb.sv
// Self-checking bench for heightmap_normal_map_stencil_top: streams images of height
// samples, predicts every packed normal and compares beats. Depends on hnm_pkg.
module heightmap_normal_map_stencil_top_tb;
  import hnm_pkg::*;

  localparam int MAXW       = 1024;
  localparam int IDLE_LIMIT = 20000;   // cycles with no beat on any channel
  localparam int RANDOM_SAMPLES = 245;

  typedef struct {
    bit [9:0]  x;
    bit [15:0] y;
    bit [7:0]  up;
    bit [7:0]  depth;
    bit [7:0]  across;
    bit        last;
  } normal_t;

  // Predicts the normal stream and holds the normals not yet seen on the output
  class normal_scoreboard;
    bit [10:0] width  = 2;
    bit [15:0] height = 2;
    bit [31:0] gain   = 32'h10000;
    bit [31:0] sx     = 32'h10000;
    bit [31:0] sz     = 32'h10000;
    bit [31:0] row_above [MAXW];
    bit [31:0] row_cur   [MAXW];
    int unsigned col = 0, row = 0;
    normal_t   pending_normals[$];
    int        errors = 0;

    function void set_reg(cfg_reg_t idx, bit [31:0] v);
      case (idx)
        REG_WIDTH:  width  = v[10:0];
        REG_HEIGHT: height = v[15:0];
        REG_GAIN:   gain   = v;
        REG_STEP_X: sx     = v;
        REG_STEP_Z: sz     = v;
        default: ;
      endcase
    endfunction

    function bit [63:0] int_sqrt(bit [63:0] s);
      bit [63:0] res, one;
      res = 0;
      one = 64'd1 << 62;
      while (one > s) one >>= 2;
      while (one != 0) begin
        if (s >= res + one) begin
          s = s - (res + one);
          res = (res >> 1) + one;
        end else begin
          res >>= 1;
        end
        one >>= 2;
      end
      return res;
    endfunction

    function bit [7:0] to_byte(longint v, bit [63:0] len);
      longint num;
      bit [63:0] q;
      num = 256 * longint'(len) + 255 * v;
      if (num < 0) return 8'd0;
      q = 64'(num) / (2 * len);
      return (q > 255) ? 8'd255 : q[7:0];
    endfunction

    // normalized cross product of (xs, g*dx, 0) and (0, g*dz, -ys), packed to bytes
    function void make_normal(bit [31:0] left, bit [31:0] right, bit [31:0] up,
                              bit [31:0] down, int cf, int rf,
                              bit [9:0] x, bit [15:0] y, bit last);
      longint dx, dz;
      bit [63:0] adx, adz, xs, ys, len, s;
      bit [127:0] m[3];
      bit [127:0] sh_m;
      bit neg[3];
      longint c[3];
      int top, sh;
      normal_t n;
      dx = longint'($signed(right)) - longint'($signed(left));
      dz = longint'($signed(down)) - longint'($signed(up));
      adx = (dx < 0) ? 64'(-dx) : 64'(dx);
      adz = (dz < 0) ? 64'(-dz) : 64'(dz);
      xs = 64'(sx) * cf;
      ys = 64'(sz) * rf;
      m[0] = 128'(gain) * 128'(adx) * 128'(ys); neg[0] = dx > 0;
      m[1] = 128'(xs) * 128'(ys);               neg[1] = 0;
      m[2] = 128'(xs) * 128'(gain) * 128'(adz); neg[2] = dz < 0;
      top = -1;
      for (int k = 0; k < 3; k++)
        for (int b = 127; b >= 0; b--)
          if (m[k][b]) begin
            if (b > top) top = b;
            break;
          end
      n.x = x; n.y = y; n.last = last;
      n.up = 8'd128; n.depth = 8'd128; n.across = 8'd128;
      if (top >= 0) begin
        sh = top - 30;
        s = 0;
        for (int k = 0; k < 3; k++) begin
          sh_m = (sh < 0) ? (m[k] << (-sh)) : (m[k] >> sh);
          c[k] = neg[k] ? -longint'(sh_m[63:0]) : longint'(sh_m[63:0]);
          s += sh_m[63:0] * sh_m[63:0];
        end
        len = int_sqrt(s);
        if (len != 0) begin
          n.up     = to_byte(c[1], len);
          n.depth  = to_byte(c[2], len);
          n.across = to_byte(c[0], len);
        end
      end
      pending_normals = {pending_normals, n};
    endfunction

    // one accepted height sample: emit the normals it completes
    function void note_sample(bit [31:0] smp);
      int unsigned w, h, x, y;
      bit [31:0] mid, above, right, left, l;
      w = (width < 2) ? 2 : ((width > MAXW) ? MAXW : width);
      h = (height < 2) ? 2 : height;
      x = (col > w - 1) ? w - 1 : col;
      y = (row > h - 1) ? h - 1 : row;
      mid   = row_cur[x];
      above = row_above[x];
      right = (x + 1 < w) ? row_cur[x+1] : mid;
      left  = (x > 0) ? row_above[x-1] : mid;
      if (y >= 1)
        make_normal(left, right, (y == 1) ? mid : above, smp,
                    (x == 0 || x == w - 1) ? 1 : 2, (y == 1) ? 1 : 2,
                    10'(x), 16'(y - 1), 0);
      row_above[x] = mid;
      row_cur[x]   = smp;
      // bottom row trails one column behind, final pixel with the last sample
      if (y == h - 1) begin
        if (x >= 1) begin
          l = (x == 1) ? row_cur[0] : row_cur[x-2];
          make_normal(l, smp, row_above[x-1], row_cur[x-1], (x == 1) ? 1 : 2, 1,
                      10'(x - 1), 16'(y), 0);
        end
        if (x == w - 1)
          make_normal(row_cur[w-2], smp, row_above[w-1], smp, 1, 1, 10'(x), 16'(y), 1);
      end
      if (x >= w - 1) begin
        col = 0;
        row = (y >= h - 1) ? 0 : y + 1;
      end else begin
        col = x + 1;
        row = y;
      end
    endfunction

    function void check_normal(bit [OUT_TDATA_W-1:0] d, bit lst);
      normal_t e;
      if (pending_normals.size() == 0) begin
        $display("%0t: unexpected normal beat tdata=%h last=%b", $time, d, lst);
        errors++;
        return;
      end
      e = pending_normals.pop_front();
      if (d[9:0] != e.x) begin
        $display("%0t: out_x expected %0d actual %0d", $time, e.x, d[9:0]); errors++;
      end
      if (d[25:10] != e.y) begin
        $display("%0t: out_y expected %0d actual %0d", $time, e.y, d[25:10]); errors++;
      end
      if (d[33:26] != e.up) begin
        $display("%0t: byte_up (%0d,%0d) expected %0d actual %0d",
                 $time, e.x, e.y, e.up, d[33:26]); errors++;
      end
      if (d[41:34] != e.depth) begin
        $display("%0t: byte_depth (%0d,%0d) expected %0d actual %0d",
                 $time, e.x, e.y, e.depth, d[41:34]); errors++;
      end
      if (d[49:42] != e.across) begin
        $display("%0t: byte_across (%0d,%0d) expected %0d actual %0d",
                 $time, e.x, e.y, e.across, d[49:42]); errors++;
      end
      if (d[55:50] != 0) begin
        $display("%0t: tdata pad expected 0 actual %h", $time, d[55:50]); errors++;
      end
      if (lst != e.last) begin
        $display("%0t: last (%0d,%0d) expected %b actual %b",
                 $time, e.x, e.y, e.last, lst); errors++;
      end
    endfunction
  endclass

  logic clk, rst;
  logic s_tvalid, s_tready;
  logic [IN_TDATA_W-1:0] s_tdata;
  logic m_tvalid, m_tready;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic m_tlast;
  logic cfg_valid, cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [31:0] cfg_data;

  normal_scoreboard sb = new();
  bit no_gaps = 0;           // stretch with no idling on either side
  int idle_cycles = 0;
  int stall_left = 0;
  int random_samples = 0;

  heightmap_normal_map_stencil_top #(.MAX_WIDTH(MAXW)) i_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  function int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 60) return 0;
    if (r < 95) return $urandom_range(1, 4);
    return $urandom_range(10, 60);
  endfunction

  // result side: random stalls, check on every accepted beat
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 0;
      stall_left <= 0;
    end else begin
      if (m_tvalid && m_tready) sb.check_normal(m_tdata, m_tlast);
      if (stall_left > 0) begin
        m_tready <= 0;
        stall_left <= stall_left - 1;
      end else begin
        m_tready <= 1;
        stall_left <= gap_len();
      end
    end
  end

  // watchdog: any beat on any channel restarts the count
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready) || rst)
      idle_cycles <= 0;
    else if (idle_cycles >= IDLE_LIMIT) begin
      $display("heightmap_normal_map_stencil_top_tb: done, errors");
      $finish;
    end else
      idle_cycles <= idle_cycles + 1;
  end

  task automatic wait_drained();
    while (sb.pending_normals.size() != 0) @(posedge clk);
  endtask

  // holds cfg_valid high; the caller drops it after the last write
  task automatic write_reg(cfg_reg_t idx, logic [31:0] v);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_reg(idx, v);
  endtask

  // registers change only with the block idle
  task automatic set_shape(logic [31:0] w, logic [31:0] h, logic [31:0] g,
                           logic [31:0] stx, logic [31:0] stz);
    wait_drained();
    repeat (100) @(posedge clk);
    write_reg(REG_WIDTH, w);
    write_reg(REG_HEIGHT, h);
    write_reg(REG_GAIN, g);
    write_reg(REG_STEP_X, stx);
    write_reg(REG_STEP_Z, stz);
    cfg_valid <= 0;
  endtask

  task automatic send_sample(logic [31:0] v);
    int g;
    s_tvalid <= 1;
    s_tdata  <= v;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_sample(v);
    g = gap_len();
    if (g > 0) begin
      s_tvalid <= 0;
      repeat (g) @(posedge clk);
    end
  endtask

  function logic [31:0] pick_q16();
    case ($urandom_range(0, 4))
      0: return $urandom();
      1: return $urandom_range(0, 32'h40000);
      2: return 32'h10000;
      3: return 32'hFFFF_FFFF;
      default: return $urandom_range(32'h100, 32'h8000);
    endcase
  endfunction

  // whole image; directed mode walks the sample extremes
  task automatic send_image(int w, int h, bit directed, bit counted);
    logic [31:0] v;
    v = $urandom();
    for (int i = 0; i < w * h; i++) begin
      if (directed) begin
        case (i % 4)
          0: v = 32'h7FFF_FFFF;
          1: v = 32'h8000_0000;
          2: v = 32'h0;
          default: v = 32'hFFFF_FFFF;
        endcase
      end else if ($urandom_range(0, 7) == 0) v = $urandom();
      else v = v + $urandom_range(0, 32'h3FFFF) - 32'h1FFFF;
      // once in a while hold off until the pipeline drains
      if (!directed && $urandom_range(0, 39) == 0) begin
        s_tvalid <= 0;
        @(posedge clk);
        wait_drained();
      end
      send_sample(v);
      if (counted) random_samples++;
    end
    s_tvalid <= 0;
  endtask

  initial begin
    int w, h;
    rst       <= 1;
    s_tvalid  <= 0;
    s_tdata   <= 0;
    cfg_valid <= 0;
    cfg_index <= REG_WIDTH;
    cfg_data  <= 0;
    repeat (9) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: reset defaults, full-scale steps, clamped sizes with zero vector
    send_image(2, 2, 1, 0);
    set_shape(3, 3, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_image(3, 3, 1, 0);
    set_shape(1, 0, 0, 0, 0);
    send_image(2, 2, 1, 0);
    set_shape(4, 2, 0, 32'h10000, 32'h10000);
    send_image(4, 2, 1, 0);

    // random images, mostly small
    while (random_samples < RANDOM_SAMPLES) begin
      no_gaps = ($urandom_range(0, 4) == 0);
      w = ($urandom_range(0, 5) == 0) ? $urandom_range(9, 40) : $urandom_range(2, 8);
      h = $urandom_range(2, 6);
      set_shape(w, h, pick_q16(), pick_q16(), pick_q16());
      send_image(w, h, 0, 1);
    end

    wait_drained();
    repeat (200) @(posedge clk);
    if (sb.pending_normals.size() != 0) sb.errors++;
    if (sb.errors == 0)
      $display("heightmap_normal_map_stencil_top_tb: done, clean");
    else
      $display("heightmap_normal_map_stencil_top_tb: done, errors");
    $finish;
  end

endmodule

// File: filelist.f
src/hnm_pkg.sv
src/hnm_normal.sv
src/heightmap_normal_map_stencil_top.sv
bench/heightmap_normal_map_stencil_top_tb.sv
